// ===== hw/rtl/avt_pkg.sv =====
// Shared constants for the affine vector transform block.
// Field widths, matrix dimensions, pipeline latency, configuration register
// indexes and parameter defaults. No dependencies.
package avt_pkg;

    localparam int FIELD_W        = 32;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int ROWS           = 3;
    localparam int COLS           = 3;
    localparam int PIPE_LATENCY   = 4;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_C23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY = 3'd6;

endpackage

// ===== hw/rtl/affine_vector_transform.sv =====
// Top level of the affine vector transform: 3x4 fixed-point matrix times vector.
// Depends on avt_pkg.
//
// Usage:
//   Input: a beat is taken at each rising edge with i_start high and o_busy
//   low. o_busy is high only while reset is asserted, so one vector can be
//   started in every cycle.
//   Output: each result is shown for one cycle with o_done high; the receiver
//   cannot stall, and none is needed since nothing is held back.
//   Pipeline: an accepted beat passes through the registered stages in order
//   (input register, multiply, add, clip) to the result. Throughput: 1 beat/cycle,
//   set by the nine parallel multipliers in the multiply stage.
//   Config: i_cfg_we writes register i_cfg_addr from i_cfg_wdata at once; the
//   user must write it only while no beat is in flight; the block does not enforce it. Unknown indexes are ignored.
//   Reset: synchronous, active low. The matrix returns to identity with
//   identity mode on, and any beats in flight are dropped.
//   Identity mode passes the input bits through with o_saturated low.
module affine_vector_transform #(
    parameter int DATA_WIDTH = avt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = avt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [avt_pkg::FIELD_W-1:0]  i_vec_x,
    input  logic signed [avt_pkg::FIELD_W-1:0]  i_vec_y,
    input  logic signed [avt_pkg::FIELD_W-1:0]  i_vec_z,
    input  logic                                i_add_translation,
    input  logic                                i_cfg_we,
    input  logic        [avt_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic        [avt_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                                o_done,
    output logic signed [avt_pkg::FIELD_W-1:0]  o_out_x,
    output logic signed [avt_pkg::FIELD_W-1:0]  o_out_y,
    output logic signed [avt_pkg::FIELD_W-1:0]  o_out_z,
    output logic                                o_saturated
);

    localparam int FW   = avt_pkg::FIELD_W;
    localparam int NR   = avt_pkg::ROWS;
    localparam int NC   = avt_pkg::COLS;
    localparam int PW   = 2 * DATA_WIDTH;
    localparam int SW   = PW - FRAC_BITS;
    localparam int SUMW = SW + 2;

    localparam logic [FW-1:0] ONE = FW'(64'd1 << FRAC_BITS);
    localparam logic signed [SUMW-1:0] SUM_MAX =
        SUMW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] SUM_MIN = -SUM_MAX - SUMW'(1);
    localparam logic signed [DATA_WIDTH-1:0] CLIP_MAX = DATA_WIDTH'(SUM_MAX);
    localparam logic signed [DATA_WIDTH-1:0] CLIP_MIN = DATA_WIDTH'(SUM_MIN);

    // configuration
    logic [avt_pkg::CFG_W-1:0] r_c01 [NR];
    logic [avt_pkg::CFG_W-1:0] r_c23 [NR];
    logic                      r_ident;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c01[0] <= {{FW{1'b0}}, ONE};
            r_c01[1] <= {ONE, {FW{1'b0}}};
            r_c01[2] <= '0;
            r_c23[0] <= '0;
            r_c23[1] <= '0;
            r_c23[2] <= {{FW{1'b0}}, ONE};
            r_ident  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                avt_pkg::CFG_ROW0_C01: r_c01[0] <= i_cfg_wdata;
                avt_pkg::CFG_ROW0_C23: r_c23[0] <= i_cfg_wdata;
                avt_pkg::CFG_ROW1_C01: r_c01[1] <= i_cfg_wdata;
                avt_pkg::CFG_ROW1_C23: r_c23[1] <= i_cfg_wdata;
                avt_pkg::CFG_ROW2_C01: r_c01[2] <= i_cfg_wdata;
                avt_pkg::CFG_ROW2_C23: r_c23[2] <= i_cfg_wdata;
                avt_pkg::CFG_IDENTITY: r_ident  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic signed [DATA_WIDTH-1:0] w_coef  [NR][NC];
    logic signed [DATA_WIDTH-1:0] w_trans [NR];

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            w_coef[r][0] = r_c01[r][DATA_WIDTH-1:0];
            w_coef[r][1] = r_c01[r][FW+DATA_WIDTH-1:FW];
            w_coef[r][2] = r_c23[r][DATA_WIDTH-1:0];
            w_trans[r]   = r_c23[r][FW+DATA_WIDTH-1:FW];
        end
    end

    assign o_busy = ~i_rst_n;

    // stage 1: input register
    logic                         r_s1_vld;
    logic                         r_s1_ident;
    logic                         r_s1_point;
    logic        [FW-1:0]         r_s1_raw [NC];
    logic signed [DATA_WIDTH-1:0] r_s1_vec [NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s1_ident  <= r_ident;
            r_s1_point  <= i_add_translation;
            r_s1_raw[0] <= i_vec_x;
            r_s1_raw[1] <= i_vec_y;
            r_s1_raw[2] <= i_vec_z;
            r_s1_vec[0] <= i_vec_x[DATA_WIDTH-1:0];
            r_s1_vec[1] <= i_vec_y[DATA_WIDTH-1:0];
            r_s1_vec[2] <= i_vec_z[DATA_WIDTH-1:0];
        end
    end

    // stage 2: products, floor-shifted by FRAC_BITS
    logic signed [PW-1:0]         w_prod  [NR][NC];
    logic signed [SW-1:0]         n_s2_prod [NR][NC];
    logic signed [DATA_WIDTH-1:0] n_s2_trans [NR];

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            for (int c = 0; c < NC; c++) begin
                w_prod[r][c]    = PW'(w_coef[r][c]) * PW'(r_s1_vec[c]);
                n_s2_prod[r][c] = w_prod[r][c][PW-1:FRAC_BITS];
            end
            n_s2_trans[r] = r_s1_point ? w_trans[r] : '0;
        end
    end

    logic                         r_s2_vld;
    logic                         r_s2_ident;
    logic        [FW-1:0]         r_s2_raw   [NC];
    logic signed [SW-1:0]         r_s2_prod  [NR][NC];
    logic signed [DATA_WIDTH-1:0] r_s2_trans [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_ident <= r_s1_ident;
            r_s2_raw   <= r_s1_raw;
            r_s2_prod  <= n_s2_prod;
            r_s2_trans <= n_s2_trans;
        end
    end

    // stage 3: exact row sums
    logic signed [SUMW-1:0] n_s3_sum [NR];

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            n_s3_sum[r] = SUMW'(r_s2_prod[r][0]) + SUMW'(r_s2_prod[r][1])
                        + SUMW'(r_s2_prod[r][2]) + SUMW'(r_s2_trans[r]);
        end
    end

    logic                   r_s3_vld;
    logic                   r_s3_ident;
    logic [FW-1:0]          r_s3_raw [NC];
    logic signed [SUMW-1:0] r_s3_sum [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_s3_ident <= r_s2_ident;
            r_s3_raw   <= r_s2_raw;
            r_s3_sum   <= n_s3_sum;
        end
    end

    // stage 4: clip and output register
    logic signed [DATA_WIDTH-1:0] w_clip [NR];
    logic        [NR-1:0]         w_clipped;
    logic signed [FW-1:0]         n_out [NR];
    logic                         n_sat;

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            if (r_s3_sum[r] > SUM_MAX) begin
                w_clip[r]    = CLIP_MAX;
                w_clipped[r] = 1'b1;
            end else if (r_s3_sum[r] < SUM_MIN) begin
                w_clip[r]    = CLIP_MIN;
                w_clipped[r] = 1'b1;
            end else begin
                w_clip[r]    = r_s3_sum[r][DATA_WIDTH-1:0];
                w_clipped[r] = 1'b0;
            end
            n_out[r] = r_s3_ident ? r_s3_raw[r] : FW'(w_clip[r]);
        end
        n_sat = r_s3_vld & ~r_s3_ident & (|w_clipped);
    end

    logic r_done;
    logic r_sat;
    logic signed [FW-1:0] r_out [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= r_s3_vld;
            r_sat  <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done      = r_done;
    assign o_saturated = r_sat;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];

endmodule

// ===== hw/rtl/avt_checker.sv =====
// Port-level checks for affine_vector_transform, bound to every instance.
// Depends on avt_pkg.
module avt_checker #(
    parameter int DATA_WIDTH = avt_pkg::DATA_WIDTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_start,
    input logic                                o_busy,
    input logic                                o_done,
    input logic signed [avt_pkg::FIELD_W-1:0]  o_out_x,
    input logic signed [avt_pkg::FIELD_W-1:0]  o_out_y,
    input logic signed [avt_pkg::FIELD_W-1:0]  o_out_z,
    input logic                                o_saturated
);

    localparam int FW = avt_pkg::FIELD_W;
    localparam int LAT = avt_pkg::PIPE_LATENCY;
    localparam logic signed [FW-1:0] MAXV = FW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [FW-1:0] MINV = -MAXV - FW'(1);

    logic w_beat_in;
    assign w_beat_in = i_start && !o_busy;

    // every accepted beat comes out after the fixed latency
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat_in |-> ##LAT o_done)
        else $error("accepted beat produced no result");

    // no result without a matching accepted beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_beat_in, LAT))
        else $error("result without a matching beat");

    a_sat_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_done)
        else $error("saturated flag outside a result beat");

    // a clipped result must show a rail value on some component
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> (o_out_x == MAXV || o_out_x == MINV ||
                         o_out_y == MAXV || o_out_y == MINV ||
                         o_out_z == MAXV || o_out_z == MINV))
        else $error("saturated flag set with no component at a rail");

endmodule

bind affine_vector_transform avt_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_avt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_z     (o_out_z),
    .o_saturated (o_saturated)
);
